/* rtl/core/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/nedf_pkg.sv */
// Package with the sizes, codes and slot record type of the EDF scheduler.
`default_nettype none

package nedf_pkg;

    // Table and time sizes.
    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int CNT_BITS  = SLOT_BITS + 1;

    // Fixed widths of the word fields.
    localparam int FIELD_BITS      = 16;
    localparam int SLOT_FIELD_BITS = 4;

    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    // Operation codes of an input word.
    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // One job slot as kept in the slot memory.
    typedef struct packed {
        logic [TIME_BITS:0]   abs_deadline;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] remaining;
        logic [TIME_BITS-1:0] first_run;
    } slot_rec_t;

    localparam int REC_BITS = $bits(slot_rec_t);

    // Clamps a field value to the largest time value.
    function automatic logic [TIME_BITS-1:0] sat_field(input logic [FIELD_BITS-1:0] v);
        logic [32:0] wide_v;
        logic [32:0] wide_max;
        wide_v   = 33'(v);
        wide_max = 33'(TMAX);
        if (wide_v > wide_max) begin
            return TMAX;
        end
        return TIME_BITS'(v);
    endfunction

    // Adds one to a time value, sticking at the largest value.
    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] t);
        if (t == TMAX) begin
            return TMAX;
        end
        return t + TIME_BITS'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/nedf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module nedf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; contents have no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nonpreemptive_edf_scheduler_unit.sv */
// Top level of the non-preemptive earliest-deadline-first job scheduler.
//
// A word is taken when start is high and busy is low, and its result appears
// on the result ports for one cycle with done high; the receiver cannot stall.
// An admit word or a tick with no job in the table leaves busy low and gives
// its result in the next cycle. A tick that continues a running job holds busy
// through the LOAD and EXEC states (slot-memory read, then update). A tick that
// must dispatch holds busy through the SCAN and EXEC states: the slot memory has
// one read port, so the earliest-deadline search reads one slot per cycle,
// then the EXEC state updates and writes back. The result appears as busy
// falls. Valid bits sit in flip-flops, so no clearing pass is run after reset.
`default_nettype none
`include "assert_macros.svh"

module nonpreemptive_edf_scheduler_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 op,
    input  wire logic [nedf_pkg::FIELD_BITS-1:0]      service_time,
    input  wire logic [nedf_pkg::FIELD_BITS-1:0]      rel_deadline,
    output logic                                      done,
    output logic                                      accepted,
    output logic [nedf_pkg::SLOT_FIELD_BITS-1:0]      slot,
    output logic                                      ran,
    output logic                                      started,
    output logic                                      finished,
    output logic [nedf_pkg::FIELD_BITS-1:0]           wait_time,
    output logic [nedf_pkg::FIELD_BITS-1:0]           turnaround,
    output logic                                      met_deadline,
    output logic                                      all_idle
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_EXEC
    } state_t;

    state_t                                state_reg;
    logic [nedf_pkg::NUM_SLOTS-1:0]        valid_reg;
    logic                                  job_running_reg;
    logic [nedf_pkg::SLOT_BITS-1:0]        running_slot_reg;
    logic [nedf_pkg::TIME_BITS-1:0]        cur_time_reg;
    logic [nedf_pkg::CNT_BITS-1:0]         cnt_reg;
    logic                                  found_reg;
    logic                                  dispatch_reg;
    logic [nedf_pkg::SLOT_BITS-1:0]        best_slot_reg;
    nedf_pkg::slot_rec_t                   best_rec_reg;

    logic                                  done_reg;
    logic                                  accepted_reg;
    logic [nedf_pkg::SLOT_FIELD_BITS-1:0]  slot_reg;
    logic                                  ran_reg;
    logic                                  started_reg;
    logic                                  finished_reg;
    logic [nedf_pkg::FIELD_BITS-1:0]       wait_time_reg;
    logic [nedf_pkg::FIELD_BITS-1:0]       turnaround_reg;
    logic                                  met_deadline_reg;
    logic                                  all_idle_reg;

    logic                                  accept;
    logic                                  run_ok;
    logic                                  free_found;
    logic [nedf_pkg::SLOT_BITS-1:0]        free_idx;
    logic [nedf_pkg::TIME_BITS-1:0]        svc_sat;
    logic [nedf_pkg::TIME_BITS-1:0]        rel_sat;
    nedf_pkg::slot_rec_t                   admit_rec;
    nedf_pkg::slot_rec_t                   rd_rec;
    logic [nedf_pkg::SLOT_BITS-1:0]        scan_prev;
    logic                                  scan_take;
    logic [nedf_pkg::TIME_BITS-1:0]        rem_dec;
    logic                                  ex_fin;
    logic [nedf_pkg::TIME_BITS-1:0]        fin_time;
    logic [nedf_pkg::TIME_BITS-1:0]        first_run;
    nedf_pkg::slot_rec_t                   upd_rec;
    logic [nedf_pkg::NUM_SLOTS-1:0]        valid_next;

    logic                                  ram_wr_en;
    logic [nedf_pkg::SLOT_BITS-1:0]        ram_wr_addr;
    logic [nedf_pkg::REC_BITS-1:0]         ram_wr_data;
    logic                                  ram_rd_en;
    logic [nedf_pkg::SLOT_BITS-1:0]        ram_rd_addr;
    logic [nedf_pkg::REC_BITS-1:0]         ram_rd_data;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);
    assign run_ok = job_running_reg && valid_reg[running_slot_reg];

    // Lowest free slot for an admit.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = nedf_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = nedf_pkg::SLOT_BITS'(i);
            end
        end
    end

    // New slot record for an admit; a zero service time counts as one tick.
    always_comb
    begin
        svc_sat = nedf_pkg::sat_field(service_time);
        if (svc_sat == '0)
        begin
            svc_sat = nedf_pkg::TIME_BITS'(1);
        end
        rel_sat                = nedf_pkg::sat_field(rel_deadline);
        admit_rec.abs_deadline = {1'b0, cur_time_reg} + {1'b0, rel_sat};
        admit_rec.arrival      = cur_time_reg;
        admit_rec.remaining    = svc_sat;
        admit_rec.first_run    = '0;
    end

    // Search step: the word read last cycle beats the best so far if its
    // deadline is earlier, or equal with an earlier arrival.
    assign rd_rec    = nedf_pkg::slot_rec_t'(ram_rd_data);
    assign scan_prev = nedf_pkg::SLOT_BITS'(cnt_reg - nedf_pkg::CNT_BITS'(1));
    assign scan_take = (cnt_reg != '0) && valid_reg[scan_prev] &&
                       (!found_reg ||
                        (rd_rec.abs_deadline < best_rec_reg.abs_deadline) ||
                        ((rd_rec.abs_deadline == best_rec_reg.abs_deadline) &&
                         (rd_rec.arrival < best_rec_reg.arrival)));

    // Execution of the selected job for one tick.
    always_comb
    begin
        rem_dec   = best_rec_reg.remaining - nedf_pkg::TIME_BITS'(1);
        ex_fin    = (best_rec_reg.remaining <= nedf_pkg::TIME_BITS'(1));
        fin_time  = nedf_pkg::sat_inc(cur_time_reg);
        first_run = dispatch_reg ? cur_time_reg : best_rec_reg.first_run;
        upd_rec              = best_rec_reg;
        upd_rec.remaining    = ex_fin ? '0 : rem_dec;
        upd_rec.first_run    = first_run;
        valid_next           = valid_reg;
        if (ex_fin)
        begin
            valid_next[best_slot_reg] = 1'b0;
        end
    end

    // Slot memory ports.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = free_idx;
        ram_wr_data = admit_rec;
        if (state_reg == ST_EXEC)
        begin
            ram_wr_en   = !ex_fin;
            ram_wr_addr = best_slot_reg;
            ram_wr_data = upd_rec;
        end
        else if (accept && (op == nedf_pkg::OP_ADMIT))
        begin
            ram_wr_en = free_found;
        end

        ram_rd_en   = 1'b0;
        ram_rd_addr = running_slot_reg;
        if (state_reg == ST_SCAN)
        begin
            ram_rd_en   = (cnt_reg < nedf_pkg::CNT_BITS'(nedf_pkg::NUM_SLOTS));
            ram_rd_addr = cnt_reg[nedf_pkg::SLOT_BITS-1:0];
        end
        else if (accept && (op == nedf_pkg::OP_TICK))
        begin
            ram_rd_en = run_ok;
        end
    end

    nedf_ram #(
        .WIDTH (nedf_pkg::REC_BITS),
        .DEPTH (nedf_pkg::NUM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Payload registers of the search; no reset needed.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            best_rec_reg <= rd_rec;
        end
        else if ((state_reg == ST_SCAN) && scan_take)
        begin
            best_rec_reg <= rd_rec;
        end
    end

    // Control state machine and registered result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            job_running_reg  <= 1'b0;
            running_slot_reg <= '0;
            cur_time_reg     <= '0;
            cnt_reg          <= '0;
            found_reg        <= 1'b0;
            dispatch_reg     <= 1'b0;
            best_slot_reg    <= '0;
            done_reg         <= 1'b0;
            accepted_reg     <= 1'b0;
            slot_reg         <= '0;
            ran_reg          <= 1'b0;
            started_reg      <= 1'b0;
            finished_reg     <= 1'b0;
            wait_time_reg    <= '0;
            turnaround_reg   <= '0;
            met_deadline_reg <= 1'b0;
            all_idle_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (op == nedf_pkg::OP_ADMIT)
                        begin
                            // Admit finishes here; the table is never empty after it.
                            done_reg         <= 1'b1;
                            accepted_reg     <= free_found;
                            slot_reg         <= free_found ?
                                                nedf_pkg::SLOT_FIELD_BITS'(free_idx) : '0;
                            ran_reg          <= 1'b0;
                            started_reg      <= 1'b0;
                            finished_reg     <= 1'b0;
                            wait_time_reg    <= '0;
                            turnaround_reg   <= '0;
                            met_deadline_reg <= 1'b0;
                            all_idle_reg     <= 1'b0;
                            if (free_found)
                            begin
                                valid_reg[free_idx] <= 1'b1;
                            end
                        end
                        else if (run_ok)
                        begin
                            // Continue the running job.
                            best_slot_reg <= running_slot_reg;
                            dispatch_reg  <= 1'b0;
                            state_reg     <= ST_LOAD;
                        end
                        else if (valid_reg == '0)
                        begin
                            // Idle tick: nothing runs and time stands still.
                            done_reg         <= 1'b1;
                            accepted_reg     <= 1'b0;
                            slot_reg         <= '0;
                            ran_reg          <= 1'b0;
                            started_reg      <= 1'b0;
                            finished_reg     <= 1'b0;
                            wait_time_reg    <= '0;
                            turnaround_reg   <= '0;
                            met_deadline_reg <= 1'b0;
                            all_idle_reg     <= 1'b1;
                        end
                        else
                        begin
                            // Dispatch: search all slots for the earliest deadline.
                            job_running_reg <= 1'b0;
                            cnt_reg         <= '0;
                            found_reg       <= 1'b0;
                            dispatch_reg    <= 1'b1;
                            state_reg       <= ST_SCAN;
                        end
                    end
                end

                ST_LOAD:
                begin
                    state_reg <= ST_EXEC;
                end

                ST_SCAN:
                begin
                    if (scan_take)
                    begin
                        best_slot_reg <= scan_prev;
                        found_reg     <= 1'b1;
                    end
                    cnt_reg <= cnt_reg + nedf_pkg::CNT_BITS'(1);
                    if (cnt_reg == nedf_pkg::CNT_BITS'(nedf_pkg::NUM_SLOTS))
                    begin
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC:
                begin
                    // Run one tick, report, and free the slot on completion.
                    done_reg         <= 1'b1;
                    accepted_reg     <= 1'b0;
                    slot_reg         <= nedf_pkg::SLOT_FIELD_BITS'(best_slot_reg);
                    ran_reg          <= 1'b1;
                    started_reg      <= dispatch_reg;
                    finished_reg     <= ex_fin;
                    wait_time_reg    <= ex_fin ?
                        nedf_pkg::FIELD_BITS'(first_run - best_rec_reg.arrival) : '0;
                    turnaround_reg   <= ex_fin ?
                        nedf_pkg::FIELD_BITS'(fin_time - best_rec_reg.arrival) : '0;
                    met_deadline_reg <= ex_fin &&
                        ({1'b0, fin_time} <= best_rec_reg.abs_deadline);
                    all_idle_reg     <= (valid_next == '0);
                    valid_reg        <= valid_next;
                    running_slot_reg <= best_slot_reg;
                    job_running_reg  <= !ex_fin;
                    cur_time_reg     <= fin_time;
                    state_reg        <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign slot         = slot_reg;
    assign ran          = ran_reg;
    assign started      = started_reg;
    assign finished     = finished_reg;
    assign wait_time    = wait_time_reg;
    assign turnaround   = turnaround_reg;
    assign met_deadline = met_deadline_reg;
    assign all_idle     = all_idle_reg;

    // A running job always owns a valid slot.
    `ASSERT_ALWAYS(a_running_valid, !job_running_reg || valid_reg[running_slot_reg], "running job has no valid slot")
    // The executed slot is valid when its tick is applied.
    `ASSERT_ALWAYS(a_exec_valid, (state_reg != ST_EXEC) || valid_reg[best_slot_reg], "executing an empty slot")
    // The execute step always produces a result word.
    `ASSERT_NEXT(a_exec_done, state_reg == ST_EXEC, done_reg && ran_reg, "execute step gave no result")
    // A finished report belongs to a tick that ran and never to an admit.
    `ASSERT_ALWAYS(a_fin_ran, !(done_reg && finished_reg) || (ran_reg && !accepted_reg), "finish without run")
    // A dispatch search always ends with a candidate.
    `ASSERT_NEXT(a_scan_found, (state_reg == ST_SCAN) && (cnt_reg == nedf_pkg::CNT_BITS'(nedf_pkg::NUM_SLOTS)), found_reg, "search found no job")

endmodule

`default_nettype wire

/* tb/nedf_checker.sv */
// Checker that predicts and compares every result word of the EDF scheduler.
`default_nettype none

module nedf_checker
    import nedf_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          op,
    input  wire logic [FIELD_BITS-1:0]         service_time,
    input  wire logic [FIELD_BITS-1:0]         rel_deadline,
    input  wire logic                          done,
    input  wire logic                          accepted,
    input  wire logic [SLOT_FIELD_BITS-1:0]    slot,
    input  wire logic                          ran,
    input  wire logic                          started,
    input  wire logic                          finished,
    input  wire logic [FIELD_BITS-1:0]         wait_time,
    input  wire logic [FIELD_BITS-1:0]         turnaround,
    input  wire logic                          met_deadline,
    input  wire logic                          all_idle,
    input  wire logic                          wrap_up,
    output int                                 mismatches,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result word as the scheduler should produce it.
    typedef struct packed {
        logic                       accepted;
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic                       ran;
        logic                       started;
        logic                       finished;
        logic [FIELD_BITS-1:0]      wait_time;
        logic [FIELD_BITS-1:0]      turnaround;
        logic                       met_deadline;
        logic                       all_idle;
    } sched_result_t;

    sched_result_t expected_results[$];

    // Shadow copy of the job table and the scheduler state.
    logic                 job_valid    [NUM_SLOTS];
    logic [TIME_BITS:0]   job_deadline [NUM_SLOTS];
    logic [TIME_BITS-1:0] job_arrival  [NUM_SLOTS];
    logic [TIME_BITS-1:0] job_left     [NUM_SLOTS];
    logic [TIME_BITS-1:0] job_first    [NUM_SLOTS];
    logic [SLOT_BITS-1:0] run_slot;
    logic                 run_active;
    logic [TIME_BITS-1:0] now;

    // Tallies for the closing summary.
    int n_results;
    int n_admits;
    int n_rejects;
    int n_ticks;
    int n_idle_ticks;
    int n_finished;
    int n_late;
    bit summary_done;

    // Applies one word to the shadow state and returns the result it should give.
    function automatic sched_result_t predict_word(input logic word_op,
                                                   input logic [FIELD_BITS-1:0] svc_in,
                                                   input logic [FIELD_BITS-1:0] rel_in);
        sched_result_t        r;
        logic [TIME_BITS-1:0] svc;
        logic [TIME_BITS-1:0] rel;
        logic [TIME_BITS-1:0] fin;
        bit                   found;
        int                   pick;
        int                   i;
        r     = '0;
        svc   = (svc_in > FIELD_BITS'(TMAX)) ? TMAX : TIME_BITS'(svc_in);
        rel   = (rel_in > FIELD_BITS'(TMAX)) ? TMAX : TIME_BITS'(rel_in);
        found = 1'b0;
        pick  = 0;
        if (word_op == OP_ADMIT)
        begin
            // A job asking for no service still takes one tick.
            if (svc == '0)
            begin
                svc = TIME_BITS'(1);
            end
            for (i = 0; i < NUM_SLOTS && !found; i++)
            begin
                if (!job_valid[i])
                begin
                    found           = 1'b1;
                    job_valid[i]    = 1'b1;
                    job_arrival[i]  = now;
                    job_deadline[i] = {1'b0, now} + {1'b0, rel};
                    job_left[i]     = svc;
                    job_first[i]    = '0;
                    r.accepted      = 1'b1;
                    r.slot          = SLOT_FIELD_BITS'(i);
                end
            end
        end
        else
        begin
            // A dispatched job keeps the processor until it completes.
            if (run_active && job_valid[run_slot])
            begin
                pick  = int'(run_slot);
                found = 1'b1;
            end
            else
            begin
                run_active = 1'b0;
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (job_valid[i])
                    begin
                        if (!found || job_deadline[i] < job_deadline[pick] ||
                            (job_deadline[i] == job_deadline[pick] &&
                             job_arrival[i] < job_arrival[pick]))
                        begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                end
                if (found)
                begin
                    run_active      = 1'b1;
                    run_slot        = SLOT_BITS'(pick);
                    job_first[pick] = now;
                    r.started       = 1'b1;
                end
            end
            // Run the chosen job for one tick; an idle tick leaves time alone.
            if (found)
            begin
                r.slot = SLOT_FIELD_BITS'(pick);
                r.ran  = 1'b1;
                if (job_left[pick] != '0)
                begin
                    job_left[pick] = job_left[pick] - TIME_BITS'(1);
                end
                if (job_left[pick] == '0)
                begin
                    fin            = (now == TMAX) ? now : now + TIME_BITS'(1);
                    r.finished     = 1'b1;
                    r.wait_time    = FIELD_BITS'(job_first[pick] - job_arrival[pick]);
                    r.turnaround   = FIELD_BITS'(fin - job_arrival[pick]);
                    r.met_deadline = ({1'b0, fin} <= job_deadline[pick]);
                    job_valid[pick] = 1'b0;
                    run_active      = 1'b0;
                end
                now = (now == TMAX) ? now : now + TIME_BITS'(1);
            end
        end
        r.all_idle = 1'b1;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            if (job_valid[i])
            begin
                r.all_idle = 1'b0;
            end
        end
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic check_field(input string name, input logic [FIELD_BITS-1:0] got,
                               input logic [FIELD_BITS-1:0] want);
        if (got !== want)
        begin
            flag_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                    n_results, name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        sched_result_t pred;
        int            i;
        if (!rst_n)
        begin
            for (i = 0; i < NUM_SLOTS; i++)
            begin
                job_valid[i] = 1'b0;
            end
            run_slot     = '0;
            run_active   = 1'b0;
            now          = '0;
            expected_results.delete();
            mismatches   = 0;
            outstanding  <= 0;
            n_results    = 0;
            n_admits     = 0;
            n_rejects    = 0;
            n_ticks      = 0;
            n_idle_ticks = 0;
            n_finished   = 0;
            n_late       = 0;
            summary_done = 1'b0;
        end
        else
        begin
            // Compare a result word with the oldest prediction.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_mismatch($sformatf("result word with no word pending (slot %0d)",
                                            slot));
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("accepted", FIELD_BITS'(accepted), FIELD_BITS'(want.accepted));
                    check_field("slot", FIELD_BITS'(slot), FIELD_BITS'(want.slot));
                    check_field("ran", FIELD_BITS'(ran), FIELD_BITS'(want.ran));
                    check_field("started", FIELD_BITS'(started), FIELD_BITS'(want.started));
                    check_field("finished", FIELD_BITS'(finished), FIELD_BITS'(want.finished));
                    check_field("wait_time", wait_time, want.wait_time);
                    check_field("turnaround", turnaround, want.turnaround);
                    check_field("met_deadline", FIELD_BITS'(met_deadline),
                                FIELD_BITS'(want.met_deadline));
                    check_field("all_idle", FIELD_BITS'(all_idle), FIELD_BITS'(want.all_idle));
                end
                n_results = n_results + 1;
            end
            // Predict the result of a word taken at this edge.
            if (start && !busy)
            begin
                pred = predict_word(op, service_time, rel_deadline);
                expected_results.push_back(pred);
                if (op == OP_ADMIT)
                begin
                    n_admits  = n_admits + 1;
                    n_rejects = n_rejects + (pred.accepted ? 0 : 1);
                end
                else
                begin
                    n_ticks      = n_ticks + 1;
                    n_idle_ticks = n_idle_ticks + (pred.ran ? 0 : 1);
                    n_finished   = n_finished + (pred.finished ? 1 : 0);
                    n_late       = n_late + ((pred.finished && !pred.met_deadline) ? 1 : 0);
                end
            end
            // At the end, anything still pending is a lost result.
            if (wrap_up && !summary_done)
            begin
                summary_done = 1'b1;
                while (expected_results.size() != 0)
                begin
                    want = expected_results.pop_front();
                    flag_mismatch($sformatf("result never came (slot %0d, ran %0d)",
                                            want.slot, want.ran));
                end
                $display("Covered %0d admit words (%0d turned away, table full) and %0d ticks",
                         n_admits, n_rejects, n_ticks);
                $display("(%0d idle); %0d jobs completed, %0d of them past their deadline.",
                         n_idle_ticks, n_finished, n_late);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

/* tb/tb_nonpreemptive_edf_scheduler_unit.sv */
// Top of the EDF scheduler testbench: clock, reset, stimulus and verdict.
`default_nettype none

module tb_nonpreemptive_edf_scheduler_unit;
    import nedf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       op = OP_ADMIT;
    logic [FIELD_BITS-1:0]      service_time = '0;
    logic [FIELD_BITS-1:0]      rel_deadline = '0;
    logic                       busy;
    logic                       done;
    logic                       accepted;
    logic [SLOT_FIELD_BITS-1:0] slot;
    logic                       ran;
    logic                       started;
    logic                       finished;
    logic [FIELD_BITS-1:0]      wait_time;
    logic [FIELD_BITS-1:0]      turnaround;
    logic                       met_deadline;
    logic                       all_idle;
    logic                       wrap_up = 1'b0;
    int                         mismatches;
    int                         outstanding;

    // Chance in percent that the sender holds start low before presenting a word.
    int                         idle_pct = 0;
    // Last relative deadline handed out, reused to force deadline ties.
    logic [FIELD_BITS-1:0]      last_rel = '0;
    // All-idle flag of the most recent result word.
    logic                       table_clear = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nonpreemptive_edf_scheduler_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .service_time (service_time),
        .rel_deadline (rel_deadline),
        .done         (done),
        .accepted     (accepted),
        .slot         (slot),
        .ran          (ran),
        .started      (started),
        .finished     (finished),
        .wait_time    (wait_time),
        .turnaround   (turnaround),
        .met_deadline (met_deadline),
        .all_idle     (all_idle)
    );

    nedf_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .service_time (service_time),
        .rel_deadline (rel_deadline),
        .done         (done),
        .accepted     (accepted),
        .slot         (slot),
        .ran          (ran),
        .started      (started),
        .finished     (finished),
        .wait_time    (wait_time),
        .turnaround   (turnaround),
        .met_deadline (met_deadline),
        .all_idle     (all_idle),
        .wrap_up      (wrap_up),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
    begin
        if (done)
        begin
            table_clear <= all_idle;
        end
    end

    // Presents one word from a falling edge and returns at the falling edge after it is taken.
    task automatic send_word(input logic word_op, input logic [FIELD_BITS-1:0] svc,
                             input logic [FIELD_BITS-1:0] rel);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        op           <= word_op;
        service_time <= svc;
        rel_deadline <= rel;
        while (busy)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic wait_results();
        start <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Ticks one word at a time until the table reports no job left.
    task automatic drain_table();
        while (!table_clear)
        begin
            send_word(OP_TICK, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
            wait_results();
        end
    endtask

    // Service demand: mostly short jobs, now and then a zero or a longer one.
    function automatic logic [FIELD_BITS-1:0] pick_service();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            return '0;
        end
        else if (roll < 70)
        begin
            return FIELD_BITS'($urandom_range(2, 1));
        end
        else if (roll < 95)
        begin
            return FIELD_BITS'($urandom_range(10, 3));
        end
        return FIELD_BITS'($urandom_range(40, 11));
    endfunction

    // Relative deadline: tight, loose, a repeat of the last one, or anything at all.
    function automatic logic [FIELD_BITS-1:0] pick_deadline();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
        begin
            last_rel = FIELD_BITS'($urandom_range(8, 0));
        end
        else if (roll < 70)
        begin
            last_rel = FIELD_BITS'($urandom_range(80, 9));
        end
        else if (roll < 85)
        begin
            last_rel = last_rel;
        end
        else
        begin
            last_rel = FIELD_BITS'($urandom);
        end
        return last_rel;
    endfunction

    // Bursts of admits followed by runs of ticks, with some noise words mixed in.
    task automatic run_random_phase(input int n_words);
        int sent;
        int n_admit;
        int n_tick;
        int k;
        logic noise_op;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(99) < 80)
            begin
                n_admit = ($urandom_range(9) == 0) ? $urandom_range(18, 10) : $urandom_range(3, 1);
                for (k = 0; k < n_admit; k++)
                begin
                    send_word(OP_ADMIT, pick_service(), pick_deadline());
                end
                n_tick = $urandom_range(30, 4);
                for (k = 0; k < n_tick; k++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_word(OP_ADMIT, pick_service(), pick_deadline());
                    end
                    else
                    begin
                        send_word(OP_TICK, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
                    end
                end
                sent = sent + n_admit + n_tick;
            end
            else
            begin
                for (k = 0; k < 4; k++)
                begin
                    noise_op = 1'($urandom);
                    send_word(noise_op,
                              (noise_op == OP_TICK) ? FIELD_BITS'($urandom)
                                                    : FIELD_BITS'($urandom_range(63)),
                              FIELD_BITS'($urandom));
                end
                sent = sent + 4;
            end
        end
    endtask

    initial
    begin
        int phase;
        int k;
        int phase_idle[4];
        phase_idle = '{0, 71, 31, 0};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words: idle tick, zero service, deadline ties, no preemption.
        send_word(OP_TICK, '0, '0);
        send_word(OP_ADMIT, '0, '0);
        send_word(OP_TICK, '1, '1);
        send_word(OP_ADMIT, FIELD_BITS'(2), '1);
        send_word(OP_ADMIT, FIELD_BITS'(1), '1);
        send_word(OP_ADMIT, FIELD_BITS'(1), FIELD_BITS'(3));
        send_word(OP_TICK, '0, '0);
        send_word(OP_TICK, '0, '0);
        send_word(OP_ADMIT, FIELD_BITS'(1), '0);
        send_word(OP_TICK, '0, '0);
        send_word(OP_TICK, '0, '0);

        // Fill every free slot, then knock on the full table.
        for (k = 0; k < NUM_SLOTS - 1; k++)
        begin
            send_word(OP_ADMIT, FIELD_BITS'(k % 3), (k % 2 == 0) ? '0 : FIELD_BITS'(65535 - k));
        end
        send_word(OP_ADMIT, '1, '1);
        wait_results();

        // Random phases under different sender idling, settling between phases.
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = phase_idle[phase];
            run_random_phase(125);
            wait_results();
        end

        // A long job holds the processor while urgent jobs queue behind it.
        idle_pct = 0;
        drain_table();
        send_word(OP_ADMIT, FIELD_BITS'(40), '1);
        send_word(OP_TICK, '0, '0);
        send_word(OP_ADMIT, FIELD_BITS'(2), '0);
        send_word(OP_ADMIT, FIELD_BITS'(1), '0);
        repeat (50)
        begin
            send_word(OP_TICK, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
        end
        send_word(OP_ADMIT, '0, '0);
        send_word(OP_ADMIT, FIELD_BITS'(5), '1);
        wait_results();
        drain_table();

        // Let the block settle, then collect the verdict.
        repeat (20) @(negedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop in case the block stops answering.
    initial
    begin
        #20_000_000;
        $display("Timed out waiting for the scheduler.");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
